FILE: rtl/core/rmf_pkg.sv
// Package for the running median filter: widths, the sequencer state type
// and the control word broadcast to every cell of the sorted chain.
// No dependencies.
package rmf_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int COUNT_OUT_W = 7;
    localparam int SUM_W       = SAMPLE_W + 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [SUM_W-1:0]    sum_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } rmf_state_t;

    // broadcast to all cells each cycle
    typedef struct packed {
        logic    ins_en;
        logic    scan_en;
        sample_t sample;
    } rmf_cell_ctrl_t;

endpackage

FILE: rtl/core/rmf_in_if.sv
// Input channel of the running median filter: valid/ready plus the sample word.
// Depends on rmf_pkg.
interface rmf_in_if;
    logic                 valid;
    logic                 ready;
    rmf_pkg::sample_t     sample;
    logic                 last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

FILE: rtl/core/rmf_out_if.sv
// Output channel of the running median filter: valid/ready plus the result word.
// Depends on rmf_pkg.
interface rmf_out_if;
    logic                                 valid;
    logic                                 ready;
    rmf_pkg::sample_t                     median;
    logic [rmf_pkg::COUNT_OUT_W-1:0]      stored_count;
    logic                                 overflow;

    modport source (output valid, output median, output stored_count, output overflow,
                    input ready);
    modport sink   (input valid, input median, input stored_count, input overflow,
                    output ready);
endinterface

FILE: rtl/core/rmf_cell.sv
// One cell of the sorted insertion chain: holds one stored sample, takes part
// in the shift-insert and forwards the median candidates to its right neighbor.
// Depends on rmf_pkg.
module rmf_cell #(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                    clk,
    input  rmf_pkg::rmf_cell_ctrl_t ctrl,
    input  logic [CW-1:0]           count,
    input  logic [CW-1:0]           lo_idx,
    input  logic [CW-1:0]           hi_idx,
    input  rmf_pkg::sample_t        left_val,
    input  logic                    left_gt,
    input  rmf_pkg::sample_t        left_lo,
    input  rmf_pkg::sample_t        left_hi,
    output rmf_pkg::sample_t        val,
    output logic                    gt,
    output rmf_pkg::sample_t        lo,
    output rmf_pkg::sample_t        hi
);
    import rmf_pkg::*;

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    sample_t val_reg, val_next;
    sample_t lo_reg, lo_next;
    sample_t hi_reg, hi_next;
    logic    in_range;
    logic    at_end;

    assign in_range = MY_IDX < count;
    assign at_end   = MY_IDX == count;
    assign gt       = in_range && (val_reg > ctrl.sample);

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.ins_en && (in_range || at_end))
        begin
            // shift right when the left neighbor is larger, else drop the sample here
            if (left_gt)
                val_next = left_val;
            else if (gt || at_end)
                val_next = ctrl.sample;
        end
    end

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctrl.scan_en)
        begin
            lo_next = (MY_IDX == lo_idx) ? val_reg : left_lo;
            hi_next = (MY_IDX == hi_idx) ? val_reg : left_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
    end

    assign val = val_reg;
    assign lo  = lo_reg;
    assign hi  = hi_reg;

endmodule

FILE: rtl/core/running_median_filter_top.sv
// Top level of the running median filter: sequencer, fill count, cell chain
// and output register. Depends on rmf_pkg, rmf_in_if, rmf_out_if, rmf_cell.
//
// Usage:
//   data   : input words {sample, last_sample}, taken when valid && ready.
//   result : output words {median, stored_count, overflow}, one per input word.
// Each accepted sample is inserted into a row of CAPACITY cells kept in
// ascending order, in the cycle it is accepted. The two middle entries then
// travel cell to cell down the chain to its end, and the median is formed on
// a 33-bit sum and loaded into the output register. No new word is taken
// while that scan runs: ready stays low until its result is loaded.
// When the store is full the sample is dropped and overflow is set.
// last_sample empties the store once its result is loaded.
// A new word is accepted while a finished result still waits; if the receiver
// stalls, the next scan holds at its end until the output register is free.
// Reset empties the store and drops any pending result; cell contents are not
// cleared, since only entries below the fill count are ever used.
module running_median_filter_top #(
    parameter int CAPACITY = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    rmf_in_if.sink    data,
    rmf_out_if.source result
);
    import rmf_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    rmf_state_t     state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic           ovf_reg, ovf_next;
    logic           ovf_out_reg, ovf_out_next;
    logic           last_reg, last_next;
    logic           out_valid_reg, out_valid_next;
    sample_t        median_reg, median_next;
    logic [COUNT_OUT_W-1:0] stored_reg, stored_next;

    logic           accept;
    logic           insert;
    logic           scan_done;
    logic           load;
    logic           out_take;
    logic [CW-1:0]  lo_idx;
    logic [CW-1:0]  hi_idx;
    sum_t           mid_sum;
    sum_t           mid_adj;
    rmf_cell_ctrl_t ctrl;

    sample_t cell_val   [CAPACITY];
    logic    cell_gt    [CAPACITY];
    sample_t cell_lo    [CAPACITY];
    sample_t cell_hi    [CAPACITY];
    sample_t left_val   [CAPACITY];
    logic    left_gt    [CAPACITY];
    sample_t left_lo    [CAPACITY];
    sample_t left_hi    [CAPACITY];

    assign accept    = data.valid && data.ready;
    assign insert    = accept && (count_reg < CAP);
    assign out_take  = out_valid_reg && result.ready;
    assign scan_done = (state_reg == ST_SCAN) && (scan_cnt_reg == CAP);
    assign load      = scan_done && (!out_valid_reg || result.ready);

    assign lo_idx = (count_reg - CW'(1)) >> 1;
    assign hi_idx = count_reg >> 1;

    assign ctrl.ins_en  = insert;
    assign ctrl.scan_en = (state_reg == ST_SCAN);
    assign ctrl.sample  = data.sample;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (load)   state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        data.ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: data.ready = 1'b1;
            ST_SCAN: data.ready = 1'b0;
            default: data.ready = 1'b0;
        endcase
    end

    // mean of the middle pair, truncated toward zero
    assign mid_sum = SUM_W'(cell_lo[CAPACITY-1]) + SUM_W'(cell_hi[CAPACITY-1]);
    assign mid_adj = mid_sum + SUM_W'({1'b0, mid_sum[SUM_W-1] & mid_sum[0]});

    always_comb
    begin
        count_next     = count_reg;
        scan_cnt_next  = scan_cnt_reg;
        ovf_next       = ovf_reg;
        ovf_out_next   = ovf_out_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;
        median_next    = median_reg;
        stored_next    = stored_reg;

        if (accept)
        begin
            scan_cnt_next = '0;
            ovf_next      = !insert;
            last_next     = data.last_sample;
        end
        if (insert)
            count_next = count_reg + CW'(1);

        if ((state_reg == ST_SCAN) && !scan_done)
            scan_cnt_next = scan_cnt_reg + CW'(1);

        if (out_take)
            out_valid_next = 1'b0;

        if (load)
        begin
            out_valid_next = 1'b1;
            median_next    = SAMPLE_W'(mid_adj >>> 1);
            stored_next    = COUNT_OUT_W'(count_reg);
            // overflow travels with its result word
            ovf_out_next   = ovf_reg;
            if (last_reg)
                count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ovf_reg     <= ovf_next;
        ovf_out_reg <= ovf_out_next;
        last_reg    <= last_next;
        median_reg  <= median_next;
        stored_reg  <= stored_next;
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            if (i == 0)
            begin : g_head
                assign left_val[i] = '0;
                assign left_gt[i]  = 1'b0;
                assign left_lo[i]  = '0;
                assign left_hi[i]  = '0;
            end
            else
            begin : g_link
                assign left_val[i] = cell_val[i-1];
                assign left_gt[i]  = cell_gt[i-1];
                assign left_lo[i]  = cell_lo[i-1];
                assign left_hi[i]  = cell_hi[i-1];
            end

            rmf_cell #(
                .IDX (i),
                .CW  (CW)
            ) u_cell (
                .clk      (clk),
                .ctrl     (ctrl),
                .count    (count_reg),
                .lo_idx   (lo_idx),
                .hi_idx   (hi_idx),
                .left_val (left_val[i]),
                .left_gt  (left_gt[i]),
                .left_lo  (left_lo[i]),
                .left_hi  (left_hi[i]),
                .val      (cell_val[i]),
                .gt       (cell_gt[i]),
                .lo       (cell_lo[i]),
                .hi       (cell_hi[i])
            );
        end
    endgenerate

    assign result.valid        = out_valid_reg;
    assign result.median       = median_reg;
    assign result.stored_count = stored_reg;
    assign result.overflow     = ovf_out_reg;

endmodule

FILE: tb/running_median_filter_top_tb.sv
// Self-checking testbench for running_median_filter_top: drives sample words with random
// gaps and checks each result word against a sorted-store predictor or the directed table.
// Depends on rmf_pkg, rmf_in_if, rmf_out_if and the filter RTL.
module running_median_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rmf_pkg::*;

    localparam int CAP        = 64;
    localparam int DIR_N      = 24;
    localparam int RAND_ITEMS = 1626;
    localparam int WATCHDOG   = 5000;

    localparam sample_t SMAX = 32'sh7FFF_FFFF;
    localparam sample_t SMIN = 32'sh8000_0000;

    typedef logic [COUNT_OUT_W-1:0] count_t;

    typedef struct packed {
        sample_t median;
        count_t  count;
        logic    ovf;
    } median_word_t;

    typedef struct {
        sample_t sample;
        logic    last;
        bit      known;
        sample_t median;
        count_t  count;
        logic    ovf;
    } stim_row_t;

    // rows with known set carry a result that follows directly from the inputs
    stim_row_t stim_tab [DIR_N] = '{
        '{32'sd5,          1'b0, 1'b1, 32'sd5,  7'd1, 1'b0},
        '{-32'sd3,         1'b1, 1'b1, 32'sd1,  7'd2, 1'b0},
        '{SMAX,            1'b1, 1'b1, SMAX,    7'd1, 1'b0},
        '{SMIN,            1'b1, 1'b1, SMIN,    7'd1, 1'b0},
        '{SMIN,            1'b0, 1'b1, SMIN,    7'd1, 1'b0},
        '{SMAX,            1'b1, 1'b1, 32'sd0,  7'd2, 1'b0},
        '{SMAX,            1'b0, 1'b1, SMAX,    7'd1, 1'b0},
        '{SMAX,            1'b1, 1'b1, SMAX,    7'd2, 1'b0},
        '{SMIN,            1'b0, 1'b1, SMIN,    7'd1, 1'b0},
        '{SMIN,            1'b1, 1'b1, SMIN,    7'd2, 1'b0},
        '{-32'sd7,         1'b0, 1'b1, -32'sd7, 7'd1, 1'b0},
        '{32'sd2,          1'b1, 1'b1, -32'sd2, 7'd2, 1'b0},
        '{32'sd7,          1'b0, 1'b1, 32'sd7,  7'd1, 1'b0},
        '{-32'sd2,         1'b1, 1'b1, 32'sd2,  7'd2, 1'b0},
        '{32'sd4,          1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'sd4,          1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'sd4,          1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'sd1,          1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'sd9,          1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{-32'sd100,       1'b1, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{-32'sd1,         1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'sd1,          1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'sh5555_5555,  1'b0, 1'b0, 32'sd0,  7'd0, 1'b0},
        '{32'shAAAA_AAAA,  1'b1, 1'b0, 32'sd0,  7'd0, 1'b0}
    };

    logic clk;
    logic rst_n;

    rmf_in_if  data_ch ();
    rmf_out_if result_ch ();

    running_median_filter_top #(
        .CAPACITY(CAP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .data  (data_ch),
        .result(result_ch)
    );

    sample_t      sorted_samples [$];
    int           fill_level;
    median_word_t pending_medians [$];
    int           accepted_words;
    int           err_count;
    int           idle_cycles;
    bit           steady;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Insert one sample and return the median word the filter should give.
    function automatic median_word_t next_median(sample_t x, logic last);
        median_word_t mw;
        int           pos;
        sum_t         pair_sum;
        sum_t         half;
        mw.ovf = 1'b0;
        if (fill_level < CAP)
        begin
            pos = 0;
            // equal samples: the new one goes after them
            while (pos < sorted_samples.size() && sorted_samples[pos] <= x)
                pos++;
            sorted_samples.insert(pos, x);
            fill_level++;
        end
        else
            mw.ovf = 1'b1;
        if (fill_level % 2 == 1)
            mw.median = sorted_samples[fill_level / 2];
        else
        begin
            pair_sum = sum_t'(sorted_samples[fill_level / 2 - 1])
                     + sum_t'(sorted_samples[fill_level / 2]);
            half = pair_sum / 2;
            mw.median = half[SAMPLE_W-1:0];
        end
        mw.count = count_t'(fill_level);
        if (last)
        begin
            fill_level = 0;
            sorted_samples.delete();
        end
        return mw;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 30);
        return $urandom_range(31, 200);
    endfunction

    function automatic sample_t pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return sample_t'($urandom);
        if (r < 8)
            return sample_t'(int'($urandom_range(0, 40)) - 20);
        if (r == 8)
        begin
            case ($urandom_range(0, 3))
                0: return SMIN;
                1: return SMAX;
                2: return 32'sd0;
                default: return -32'sd1;
            endcase
        end
        if ($urandom_range(0, 1) == 1)
            return SMAX - sample_t'($urandom_range(0, 3));
        return SMIN + sample_t'($urandom_range(0, 3));
    endfunction

    function automatic int pick_len(int seq_idx);
        int r;
        // first sequences: exactly full, then full with the last mark on a dropped word
        if (seq_idx == 0)
            return CAP;
        if (seq_idx == 1)
            return CAP + 3;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(1, 8);
        if (r < 75)
            return $urandom_range(9, 40);
        if (r < 90)
            return $urandom_range(41, CAP - 1);
        return $urandom_range(CAP, CAP + 8);
    endfunction

    task automatic send_word(sample_t x, logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            data_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_ch.sample      <= x;
        data_ch.last_sample <= last;
        data_ch.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!data_ch.ready);
    endtask

    // result side: bursts of ready broken by stalls
    initial
    begin
        int gap;
        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        median_word_t exp_w;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (pending_medians.size() == 0)
                begin
                    $error("result word with no expectation pending");
                    err_count++;
                end
                else
                begin
                    exp_w = pending_medians.pop_front();
                    if (result_ch.median !== exp_w.median)
                    begin
                        $error("median: expected %0d, got %0d", exp_w.median,
                               result_ch.median);
                        err_count++;
                    end
                    if (result_ch.stored_count !== exp_w.count)
                    begin
                        $error("stored_count: expected %0d, got %0d", exp_w.count,
                               result_ch.stored_count);
                        err_count++;
                    end
                    if (result_ch.overflow !== exp_w.ovf)
                    begin
                        $error("overflow: expected %0b, got %0b", exp_w.ovf,
                               result_ch.overflow);
                        err_count++;
                    end
                end
            end
            if (data_ch.valid && data_ch.ready)
            begin
                exp_w = next_median(data_ch.sample, data_ch.last_sample);
                if (accepted_words < DIR_N && stim_tab[accepted_words].known)
                begin
                    exp_w.median = stim_tab[accepted_words].median;
                    exp_w.count  = stim_tab[accepted_words].count;
                    exp_w.ovf    = stim_tab[accepted_words].ovf;
                end
                pending_medians.push_back(exp_w);
                accepted_words++;
            end
        end
    end

    // end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if ((data_ch.valid && data_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int seq_idx;
        int len;
        fill_level     = 0;
        accepted_words = 0;
        err_count      = 0;
        idle_cycles    = 0;
        steady         = 1'b0;
        rst_n               <= 1'b0;
        data_ch.valid       <= 1'b0;
        data_ch.sample      <= '0;
        data_ch.last_sample <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_tab[i])
            send_word(stim_tab[i].sample, stim_tab[i].last);

        sent    = 0;
        seq_idx = 0;
        while (sent < RAND_ITEMS)
        begin
            len    = pick_len(seq_idx);
            steady = (seq_idx % 5 == 3);
            for (int i = 0; i < len; i++)
                send_word(pick_sample(), i == len - 1);
            sent += len;
            seq_idx++;
        end
        data_ch.valid <= 1'b0;
        steady = 1'b0;

        while (pending_medians.size() != 0)
            @(posedge clk);
        repeat (CAP + 8) @(posedge clk);
        if (err_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/rmf_pkg.sv
rtl/core/rmf_in_if.sv
rtl/core/rmf_out_if.sv
rtl/core/rmf_cell.sv
rtl/core/running_median_filter_top.sv
tb/running_median_filter_top_tb.sv
